FILE: hw/rtl/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg: shared widths and helpers for stress plane resolution
// Holds the fixed-point helpers used by the pipeline stages.
// ----------------------------------------------------------------------------
package spr_pkg;

	localparam int TW = 32;   // tensor and output width
	localparam int NW = 18;   // normal width
	localparam int MW = 20;   // n_i*n_j rounded, up to 2^18 in magnitude, 20 bits signed
	localparam int AW = 56;   // accumulator width for 32x20 and 32x18 sums
	localparam int SW = 40;   // traction and shear width before saturation
	localparam int QW = 66;   // sum of squares width
	localparam int RW = 33;   // root width
	localparam int SQRT_STEPS = 33;

	// round x / 2^16, nearest, ties toward +inf: arithmetic shift of x + 2^15
	function automatic logic signed [AW-1:0] rnd16(input logic signed [AW+15:0] x);
		logic signed [AW+15:0] y;
		y = x + (AW+16)'(32768);
		return AW'(y >>> 16);
	endfunction

	function automatic logic [TW-1:0] sat32(input logic signed [AW-1:0] x);
		if (x > AW'(64'sd2147483647)) return 32'h7FFF_FFFF;
		if (x < -AW'(64'sd2147483648)) return 32'h8000_0000;
		return x[TW-1:0];
	endfunction

	typedef struct packed {
		logic [RW-1:0] r;
		logic [RW+1:0] rem;
		logic [QW-1:0] q;
	} sqrt_t;

	// one digit step of the restoring root: takes the top pair of q
	function automatic sqrt_t sqrt_step(input sqrt_t a);
		sqrt_t o;
		logic [RW+1:0] rem;
		logic [RW+1:0] trial;
		rem = {a.rem[RW-1:0], a.q[QW-1:QW-2]};
		trial = {a.r, 2'b01};
		o.q = {a.q[QW-3:0], 2'b00};
		if (rem >= trial) begin
			o.rem = rem - trial;
			o.r = {a.r[RW-2:0], 1'b1};
		end else begin
			o.rem = rem;
			o.r = {a.r[RW-2:0], 1'b0};
		end
		return o;
	endfunction

endpackage

FILE: hw/rtl/stress_plane_resolution_top.sv
// ----------------------------------------------------------------------------
// stress_plane_resolution_top: traction split into normal and shear parts
// Streams one tensor and normal in, one normal stress, shear vector and
// shear length out, through a valid-tagged pipeline.
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low bit first)                  | tuser
// s_axis  | in  | t_00..t_22 (9x32), normal_x/y/z (3x18), pad 2 | none
// m_axis  | out | normal_stress, shear_x, shear_y, shear_z,     | none
//         |     | shear_magnitude (5x32)                        |
//
// One word enters per cycle while m_axis does not stall. The pipe has five arithmetic
// stages, 33 root stages and the output register. Depth is set by the
// 33-digit square root, one digit per stage.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stall on m_axis freezes the whole pipe (global enable), so nothing is lost
// or repeated; s_axis_tready falls whenever the output word is held by a
// stall, full pipe or not.
// ----------------------------------------------------------------------------
module stress_plane_resolution_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [343:0] s_axis_tdata,  // t_00..t_22, normal_x, normal_y, normal_z, pad
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [159:0] m_axis_tdata   // normal_stress, shear_x/y/z, shear_magnitude
);

	localparam int TW = spr_pkg::TW;
	localparam int NW = spr_pkg::NW;
	localparam int MW = spr_pkg::MW;
	localparam int AW = spr_pkg::AW;
	localparam int SW = spr_pkg::SW;
	localparam int QW = spr_pkg::QW;
	localparam int NS = spr_pkg::SQRT_STEPS;

	// advance every stage when the output stage is free or being drained
	logic en;
	logic vout_q;
	assign en = !vout_q || m_axis_tready;
	assign s_axis_tready = en;

	// unpack
	logic signed [TW-1:0] t_in [9];
	logic signed [NW-1:0] n_in [3];
	always_comb begin
		for (int k = 0; k < 9; k++) t_in[k] = s_axis_tdata[k*TW +: TW];
		for (int k = 0; k < 3; k++) n_in[k] = s_axis_tdata[9*TW + k*NW +: NW];
	end

	// stage 1: products T*n (traction) and n*n
	logic v_s1;
	logic signed [TW-1:0] t_s1 [9];
	logic signed [AW-1:0] tn_s1 [9];
	logic signed [MW-1:0] m_s1 [3][3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_axis_tvalid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					t_s1[i*3+j] <= t_in[i*3+j];
					tn_s1[i*3+j] <= AW'(t_in[i*3+j] * n_in[i]);
					m_s1[i][j] <= MW'(spr_pkg::rnd16((AW+16)'(n_in[i] * n_in[j])));
				end
			end
		end
	end

	// stage 2: traction t_j and sigma accumulation products
	logic v_s2;
	logic signed [SW-1:0] tr_s2 [3];
	logic signed [MW-1:0] m_s2 [3][3];
	logic signed [AW-1:0] sp_s2 [6];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++)
				tr_s2[j] <= SW'(spr_pkg::rnd16((AW+16)'(tn_s1[j] + tn_s1[3+j] + tn_s1[6+j])));
			m_s2 <= m_s1;
			sp_s2[0] <= AW'(t_s1[0] * m_s1[0][0]);
			sp_s2[1] <= AW'(t_s1[4] * m_s1[1][1]);
			sp_s2[2] <= AW'(t_s1[8] * m_s1[2][2]);
			sp_s2[3] <= AW'(t_s1[1] * m_s1[0][1]);
			sp_s2[4] <= AW'(t_s1[5] * m_s1[1][2]);
			sp_s2[5] <= AW'(t_s1[6] * m_s1[2][0]);
		end
	end

	// stage 3: m*t products and sigma result
	logic v_s3;
	logic signed [SW-1:0] tr_s3 [3];
	logic signed [AW+3:0] mt_s3 [3][3];
	logic [TW-1:0] sig_s3;
	logic signed [AW+3:0] sacc;
	always_comb begin
		sacc = (AW+4)'(sp_s2[0]) + (AW+4)'(sp_s2[1]) + (AW+4)'(sp_s2[2])
		     + ((AW+4)'(sp_s2[3]) <<< 1) + ((AW+4)'(sp_s2[4]) <<< 1)
		     + ((AW+4)'(sp_s2[5]) <<< 1);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			tr_s3 <= tr_s2;
			sig_s3 <= spr_pkg::sat32(spr_pkg::rnd16((AW+16)'(sacc)));
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					mt_s3[i][j] <= (AW+4)'(m_s2[i][j] * tr_s2[j]);
		end
	end

	// stage 4: shear vector
	logic v_s4;
	logic signed [SW-1:0] s_s4 [3];
	logic [TW-1:0] sig_s4;
	logic signed [SW-1:0] s_c [3];
	always_comb begin
		for (int i = 0; i < 3; i++)
			s_c[i] = SW'(spr_pkg::rnd16((AW+16)'(((AW+16)'(tr_s3[i]) <<< 16)
				- (AW+16)'(mt_s3[i][0]) - (AW+16)'(mt_s3[i][1])
				- (AW+16)'(mt_s3[i][2]))));
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			s_s4 <= s_c;
			sig_s4 <= sig_s3;
		end
	end

	// stage 5: magnitudes squared, big flag, saturated components
	logic v_s5;
	logic [QW-1:0] sq_s5 [3];
	logic big_s5;
	logic [TW-1:0] sh_s5 [3];
	logic [TW-1:0] sig_s5;
	logic [SW-1:0] a_c [3];
	logic [2:0] bigv;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a_c[i] = s_s4[i][SW-1] ? SW'(-s_s4[i]) : SW'(s_s4[i]);
			bigv[i] = |a_c[i][SW-1:TW];
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= QW'(a_c[i][TW-1:0] * a_c[i][TW-1:0]);
				sh_s5[i] <= spr_pkg::sat32(AW'(s_s4[i]));
			end
			big_s5 <= |bigv;
			sig_s5 <= sig_s4;
		end
	end

	// root pipeline: one digit per stage
	logic v_r [NS+1];
	spr_pkg::sqrt_t rt [NS+1];
	logic big_r [NS+1];
	logic [TW-1:0] sig_r [NS+1];
	logic [3*TW-1:0] sh_r [NS+1];
	always_comb begin
		v_r[0] = v_s5;
		rt[0].r = '0;
		rt[0].rem = '0;
		rt[0].q = sq_s5[0] + sq_s5[1] + sq_s5[2];
		big_r[0] = big_s5;
		sig_r[0] = sig_s5;
		sh_r[0] = {sh_s5[2], sh_s5[1], sh_s5[0]};
	end
	for (genvar g = 0; g < NS; g++) begin : g_root
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_r[g+1] <= 1'b0;
			else if (en) v_r[g+1] <= v_r[g];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rt[g+1] <= spr_pkg::sqrt_step(rt[g]);
				big_r[g+1] <= big_r[g];
				sig_r[g+1] <= sig_r[g];
				sh_r[g+1] <= sh_r[g];
			end
		end
	end

	// output register
	logic [159:0] dout_q;
	logic [TW-1:0] mag;
	always_comb begin
		if (big_r[NS] || rt[NS].r[spr_pkg::RW-1]) mag = '1;
		else mag = rt[NS].r[TW-1:0];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vout_q <= 1'b0;
		else if (en) vout_q <= v_r[NS];
	end
	always_ff @(posedge clk) begin
		if (en) dout_q <= {mag, sh_r[NS], sig_r[NS]};
	end
	assign m_axis_tvalid = vout_q;
	assign m_axis_tdata = dout_q;

endmodule

FILE: hw/rtl/spr_checker.sv
// ----------------------------------------------------------------------------
// spr_checker: port-level checks for stress plane resolution
// Watches the handshakes of both channels.
// ----------------------------------------------------------------------------
module spr_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [159:0] m_axis_tdata
);

	// hold a stalled output word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word dropped or changed under stall");

	// input side stalls only while output is stalled
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

	// free output side never blocks the input
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked with empty output");

endmodule

bind stress_plane_resolution_top spr_checker u_spr_checker (.*);

FILE: tb/stress_plane_resolution_top_tb.sv
// ----------------------------------------------------------------------------
// stress_plane_resolution_top_tb: self-checking bench for stress resolution
// Drives tensor and normal words with random gaps, predicts normal stress,
// shear vector and shear length per word, and checks the output in order.
// ----------------------------------------------------------------------------
module stress_plane_resolution_top_tb;

	localparam int RAND_WORDS = 850;
	localparam int DRAIN_CYCLES = 60;
	localparam longint CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [31:0] mag;
		logic [31:0] sz;
		logic [31:0] sy;
		logic [31:0] sx;
		logic [31:0] sigma;
	} plane_res_t;

	typedef struct {
		logic signed [31:0] t [9];
		logic signed [17:0] n [3];
		bit                 has_typed;
		plane_res_t         typed;
	} plane_case_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [343:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [159:0] m_axis_tdata;

	plane_res_t   pending_res [$];
	int           fail_count = 0;
	longint       cycle_count = 0;
	bit           quiet_phase = 1'b0;
	bit           stim_done = 1'b0;
	plane_case_t  dir_rows [$];

	stress_plane_resolution_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #2 clk = ~clk;

	// round to nearest over 2^16, ties toward +infinity
	function automatic longint round_q16(input longint x);
		return (x + 64'sd32768) >>> 16;
	endfunction

	function automatic logic [31:0] clamp_s32(input longint x);
		if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
		if (x < -64'sd2147483648) return 32'h8000_0000;
		return x[31:0];
	endfunction

	// predict one output word from a tensor and a normal
	function automatic plane_res_t resolve_plane(input plane_case_t c);
		plane_res_t r;
		longint tn [3][3];
		longint nv [3];
		longint mm [3][3];
		longint tr [3];
		longint sh [3];
		longint acc;
		logic [65:0] sumsq;
		logic [65:0] rem, trial;
		logic [32:0] root;
		logic [63:0] a;
		bit big;
		big = 1'b0;
		sumsq = '0;
		for (int i = 0; i < 3; i++) begin
			nv[i] = c.n[i];
			for (int j = 0; j < 3; j++) tn[i][j] = c.t[i*3+j];
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) mm[i][j] = round_q16(nv[i] * nv[j]);
		for (int j = 0; j < 3; j++)
			tr[j] = round_q16(tn[0][j]*nv[0] + tn[1][j]*nv[1] + tn[2][j]*nv[2]);
		acc = tn[0][0]*mm[0][0] + tn[1][1]*mm[1][1] + tn[2][2]*mm[2][2]
			+ 2*(tn[0][1]*mm[0][1]) + 2*(tn[1][2]*mm[1][2]) + 2*(tn[2][0]*mm[2][0]);
		r.sigma = clamp_s32(round_q16(acc));
		for (int i = 0; i < 3; i++) begin
			acc = tr[i]*65536 - (mm[i][0]*tr[0] + mm[i][1]*tr[1] + mm[i][2]*tr[2]);
			sh[i] = round_q16(acc);
		end
		r.sx = clamp_s32(sh[0]);
		r.sy = clamp_s32(sh[1]);
		r.sz = clamp_s32(sh[2]);
		for (int i = 0; i < 3; i++) begin
			a = (sh[i] < 0) ? -sh[i] : sh[i];
			if (a > 64'hFFFF_FFFF) big = 1'b1;
			else sumsq = sumsq + 66'(a * a);
		end
		if (big) begin
			r.mag = 32'hFFFF_FFFF;
		end else begin
			root = '0;
			rem = '0;
			for (int k = 32; k >= 0; k--) begin
				rem = (rem << 2) | 66'(sumsq[2*k +: 2]);
				trial = (66'(root) << 2) | 66'd1;
				if (rem >= trial) begin
					rem = rem - trial;
					root = {root[31:0], 1'b1};
				end else begin
					root = {root[31:0], 1'b0};
				end
			end
			r.mag = root[32] ? 32'hFFFF_FFFF : root[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [17:0] rand_normal_comp();
		case ($urandom_range(0, 5))
			0: return 18'sd65536;
			1: return -18'sd65536;
			2: return 18'($urandom);
			default: return 18'($signed($urandom_range(0, 131072)) - 65536);
		endcase
	endfunction

	function automatic plane_case_t rand_case();
		plane_case_t c;
		int scale;
		scale = $urandom_range(0, 3);
		for (int i = 0; i < 9; i++) begin
			case (scale)
				0: c.t[i] = $urandom;
				1: c.t[i] = $signed($urandom) >>> 8;
				2: c.t[i] = $signed($urandom) >>> 16;
				default: c.t[i] = ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
			endcase
		end
		for (int i = 0; i < 3; i++) c.n[i] = rand_normal_comp();
		// one case in four gets a unit axis normal so shear stays sane; rest stays raw
		if ($urandom_range(0, 3) == 0) begin
			c.n = '{18'sd0, 18'sd0, 18'sd0};
			c.n[$urandom_range(0, 2)] = ($urandom_range(0, 1)) ? 18'sd65536 : -18'sd65536;
		end
		c.has_typed = 1'b0;
		c.typed = '0;
		return c;
	endfunction

	function automatic plane_case_t make_row(input logic signed [31:0] tv,
		input logic signed [17:0] nx, ny, nz, input bit typed_ok, input plane_res_t exp_r);
		plane_case_t c;
		for (int i = 0; i < 9; i++) c.t[i] = tv;
		c.n = '{nx, ny, nz};
		c.has_typed = typed_ok;
		c.typed = exp_r;
		return c;
	endfunction

	function automatic logic [343:0] pack_case(input plane_case_t c);
		logic [343:0] d;
		d = '0;
		for (int i = 0; i < 9; i++) d[i*32 +: 32] = c.t[i];
		for (int i = 0; i < 3; i++) d[288 + i*18 +: 18] = c.n[i];
		return d;
	endfunction

	// send one word; hold valid until it is taken, with random gaps before
	task automatic send_word(input plane_case_t c);
		plane_res_t want;
		want = resolve_plane(c);
		if (c.has_typed && want !== c.typed) begin
			$error("typed row disagrees with prediction: %h vs %h", c.typed, want);
			fail_count++;
		end
		if (!quiet_phase && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pack_case(c);
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_res.push_back(c.has_typed ? c.typed : want);
	endtask

	// receiver: random stall bursts, no stalls in the quiet phase
	initial begin
		m_axis_tready <= 1'b0;
		wait (arst_n);
		forever begin
			if (!quiet_phase && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// compare each accepted output word with the oldest expectation
	always @(posedge clk) begin
		plane_res_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pending_res.size() == 0) begin
				$error("output word with nothing expected: %h", got);
				fail_count++;
			end else begin
				want = pending_res.pop_front();
				if (got.sigma !== want.sigma) begin
					$error("normal_stress exp %h got %h", want.sigma, got.sigma);
					fail_count++;
				end
				if (got.sx !== want.sx) begin
					$error("shear_x exp %h got %h", want.sx, got.sx);
					fail_count++;
				end
				if (got.sy !== want.sy) begin
					$error("shear_y exp %h got %h", want.sy, got.sy);
					fail_count++;
				end
				if (got.sz !== want.sz) begin
					$error("shear_z exp %h got %h", want.sz, got.sz);
					fail_count++;
				end
				if (got.mag !== want.mag) begin
					$error("shear_magnitude exp %h got %h", want.mag, got.mag);
					fail_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		plane_res_t zero_r, x_r;
		zero_r = '0;
		// all-ones tensor entry 1.0 with normal on x: sigma 1, shear (0,1,1)
		x_r = '{mag: 32'h0001_6A09, sz: 32'h0001_0000, sy: 32'h0001_0000,
			sx: 32'h0000_0000, sigma: 32'h0001_0000};
		dir_rows.push_back(make_row(32'sd0, 18'sd0, 18'sd0, 18'sd0, 1'b1, zero_r));
		dir_rows.push_back(make_row(32'sh7FFF_FFFF, 18'sd0, 18'sd0, 18'sd0, 1'b1, zero_r));
		dir_rows.push_back(make_row(32'sh0001_0000, 18'sd65536, 18'sd0, 18'sd0, 1'b1, x_r));
		dir_rows.push_back(make_row(32'sh7FFF_FFFF, 18'sd65536, 18'sd65536, 18'sd65536,
			1'b0, zero_r));
		dir_rows.push_back(make_row(32'sh8000_0000, -18'sd65536, -18'sd65536, -18'sd65536,
			1'b0, zero_r));
		dir_rows.push_back(make_row(32'sh8000_0000, 18'sh1FFFF, 18'sh20000, 18'sh1FFFF,
			1'b0, zero_r));
		dir_rows.push_back(make_row(32'sh7FFF_FFFF, 18'sh20000, 18'sh20000, 18'sh20000,
			1'b0, zero_r));
		dir_rows.push_back(make_row(-32'sd1, 18'sh3FFFF, 18'sd1, 18'sd46341, 1'b0, zero_r));
		dir_rows.push_back(make_row(32'sd1, 18'sd46341, 18'sd46341, 18'sd0, 1'b0, zero_r));
		// non-symmetric tensor: lower entries differ from upper ones
		begin
			plane_case_t c;
			c = make_row(32'sh0002_0000, 18'sd37837, 18'sd37837, 18'sd37837, 1'b0, zero_r);
			c.t[3] = 32'sh8000_0000; c.t[7] = 32'sh7FFF_FFFF; c.t[2] = -32'sd123456;
			dir_rows.push_back(c);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) send_word(dir_rows[i]);
		for (int k = 0; k < RAND_WORDS; k++) begin
			send_word(rand_case());
			// hold off once until the pipe has drained completely
			if (k == RAND_WORDS / 2) begin
				s_axis_tvalid <= 1'b0;
				while (pending_res.size() != 0) @(posedge clk);
			end
			if (k == RAND_WORDS - 120) quiet_phase = 1'b1;
		end
		s_axis_tvalid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/spr_pkg.sv
hw/rtl/stress_plane_resolution_top.sv
hw/rtl/spr_checker.sv
tb/stress_plane_resolution_top_tb.sv
